// File: design/pkus_pkg.sv
// Package for the Poisson-kernel uniformity statistic block.
// Holds the item structs, sizes, register indexes and status codes.
// No dependencies.
package pkus_pkg;

  localparam int MAX_POINTS = 256;
  localparam int MAX_DIM    = 16;
  localparam int PT_W       = $clog2(MAX_POINTS);
  localparam int CI_W       = $clog2(MAX_DIM);
  localparam int ADDR_W     = PT_W + CI_W;
  localparam int STORE_SIZE = MAX_POINTS * MAX_DIM;

  localparam int COORD_W   = 16;
  localparam int RHO_W     = 16;
  localparam int DIM_W     = 5;
  localparam int STAT_W    = 48;
  localparam int STATUS_W  = 3;
  localparam int CFG_IDX_W = 1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_RHO = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DIM = 1'd1;

  localparam logic [RHO_W-1:0] RHO_RESET = 16'd32768;
  localparam logic [DIM_W-1:0] DIM_RESET = 5'd3;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK         = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FEW        = 3'd1;
  localparam logic [STATUS_W-1:0] ST_SATURATED  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_INCOMPLETE = 3'd3;
  localparam logic [STATUS_W-1:0] ST_TOO_MANY   = 3'd4;

  typedef struct packed {
    logic signed [COORD_W-1:0] coord;
    logic                      last;
  } in_item_t;

  typedef struct packed {
    logic signed [STAT_W-1:0] u_stat;
    logic signed [STAT_W-1:0] v_stat;
    logic [STATUS_W-1:0]      status;
  } out_item_t;

endpackage

// File: design/poisson_kernel_uniformity_statistic.sv
// Poisson-kernel uniformity statistic: point store, pair sequencer and shared arithmetic.
// Depends on pkus_pkg.
//
// Points are loaded one coordinate per item, one item per cycle, into a 4096 x 16 point
// store. The item marked last closes the sample; if the sample is well formed the block
// stops taking items and runs a compute burst over every pair (i, j) with j <= i. Per pair
// the dot product reads, multiplies and accumulates each coordinate in turn (one store
// read port, one shared multiplier); then come normalization, the power by repeated
// mantissa products, on odd dimensions a square root plus one more mantissa product,
// and a bit-serial division. After the last pair two restoring divisions form U and V.
// The result then sits in an output register, and loading of the next sample may go on
// while it waits to be taken. Error samples (too many points, incomplete point, fewer
// than two points) give their result without a burst.
module poisson_kernel_uniformity_statistic (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  pkus_pkg::in_item_t            in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output pkus_pkg::out_item_t           out_data,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [pkus_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [pkus_pkg::RHO_W-1:0]    cfg_data
);

  localparam int PT_W   = pkus_pkg::PT_W;
  localparam int CI_W   = pkus_pkg::CI_W;
  localparam int ADDR_W = pkus_pkg::ADDR_W;
  localparam int DIM_W  = pkus_pkg::DIM_W;

  // sequencer codes
  localparam logic [4:0] S_IDLE      = 5'd0;
  localparam logic [4:0] S_RSQ       = 5'd1;
  localparam logic [4:0] S_RSQ_W     = 5'd2;
  localparam logic [4:0] S_RSQ_GET   = 5'd3;
  localparam logic [4:0] S_DOT_RA    = 5'd4;
  localparam logic [4:0] S_DOT_RB    = 5'd5;
  localparam logic [4:0] S_DOT_MB    = 5'd6;
  localparam logic [4:0] S_DOT_W     = 5'd7;
  localparam logic [4:0] S_DOT_ACC   = 5'd8;
  localparam logic [4:0] S_BASE_M    = 5'd9;
  localparam logic [4:0] S_BASE_W    = 5'd10;
  localparam logic [4:0] S_BASE      = 5'd11;
  localparam logic [4:0] S_NORM      = 5'd12;
  localparam logic [4:0] S_POW_M     = 5'd13;
  localparam logic [4:0] S_POW_W     = 5'd14;
  localparam logic [4:0] S_POW_N     = 5'd15;
  localparam logic [4:0] S_SQRT_INIT = 5'd16;
  localparam logic [4:0] S_SQRT      = 5'd17;
  localparam logic [4:0] S_DIV_INIT  = 5'd18;
  localparam logic [4:0] S_DIV_QR    = 5'd19;
  localparam logic [4:0] S_DIV_SH    = 5'd20;
  localparam logic [4:0] S_TERM      = 5'd21;
  localparam logic [4:0] S_ACC       = 5'd22;
  localparam logic [4:0] S_FIN1      = 5'd23;
  localparam logic [4:0] S_FIN2      = 5'd24;
  localparam logic [4:0] S_LD_INIT   = 5'd25;
  localparam logic [4:0] S_LD        = 5'd26;
  localparam logic [4:0] S_LD_DONE   = 5'd27;
  localparam logic [4:0] S_EMIT      = 5'd28;

  localparam logic signed [48:0] TERM_MAX = 49'sh0_7FFF_FFFF_FFFF;
  localparam logic [48:0]        TERM_LIM = 49'h0_8000_0100_0000;
  localparam logic [48:0]        ONE_Q24  = 49'h0_0000_0100_0000;
  localparam logic [48:0]        Q_SAT    = 49'h1_0000_0000_0000;
  localparam logic [47:0]        POS48    = 48'h7FFF_FFFF_FFFF;
  localparam logic [47:0]        NEG48    = 48'h8000_0000_0000;

  // saturating 64-bit add, result {sat, sum}
  function automatic logic [64:0] sat_add(input logic signed [63:0] a,
                                          input logic signed [63:0] b);
    logic signed [63:0] s;
    s = a + b;
    if (!a[63] && !b[63] && s[63]) begin
      sat_add = {1'b1, 64'h7FFF_FFFF_FFFF_FFFF};
    end else if (a[63] && b[63] && !s[63]) begin
      sat_add = {1'b1, 64'h8000_0000_0000_0000};
    end else begin
      sat_add = {1'b0, s};
    end
  endfunction

  // configuration
  logic [pkus_pkg::RHO_W-1:0] rho;
  logic [DIM_W-1:0]           dimension;
  logic [DIM_W-1:0]           dim_eff;
  logic [DIM_W-2:0]           dim_half;

  // sample loading
  logic [4:0]      state;
  logic [PT_W:0]   cnt;
  logic [CI_W-1:0] ci;
  logic            ovf;
  logic [CI_W:0]   ci_inc;
  logic            pt_done;
  logic            full;
  logic [PT_W:0]   cnt_new;
  logic [CI_W-1:0] ci_new;
  logic            ovf_new;

  // point store
  logic [pkus_pkg::COORD_W-1:0] store [pkus_pkg::STORE_SIZE];
  logic [ADDR_W-1:0]            rd_addr;
  logic [pkus_pkg::COORD_W-1:0] rd_data;

  // pair walk and dot product
  logic [PT_W:0]     n_pts;
  logic [PT_W-1:0]   pi;
  logic [PT_W-1:0]   pj;
  logic [CI_W-1:0]   cc;
  logic signed [36:0] dot;

  // shared multiplier
  logic signed [32:0] mul_a;
  logic signed [36:0] mul_b;
  logic signed [69:0] mul_p;
  logic [31:0]        rsq;

  // kernel term datapath
  logic signed [55:0] base;
  logic [63:0]        nx;
  logic [5:0]         sh;
  logic [31:0]        pm;
  logic signed [11:0] pe;
  logic [31:0]        fm;
  logic signed [11:0] fe;
  logic [DIM_W-2:0]   kk;
  logic               last_mul;
  logic [63:0]        prod;
  logic signed [11:0] se_val;
  logic [63:0]        sx;
  logic [31:0]        sres;
  logic [32:0]        srem;
  logic [4:0]         scnt;
  logic [34:0]        s_rem2;
  logic [34:0]        s_trial;
  logic               s_ge;
  logic signed [12:0] s_amt;
  logic [48:0]        qq;
  logic [32:0]        rr;
  logic [11:0]        dcnt;
  logic [32:0]        d_r2;
  logic               d_ge;
  logic [48:0]        d_qn;
  logic signed [48:0] term;
  logic               sat;

  // sums and final division
  logic signed [63:0] lower_sum;
  logic signed [63:0] diag_sum;
  logic signed [63:0] two_lower;
  logic signed [63:0] total;
  logic [64:0]        add_res;
  logic [64:0]        fin_res;
  logic               ld_sel;
  logic               ld_neg;
  logic [63:0]        ld_q;
  logic [15:0]        ld_den;
  logic [16:0]        ld_rem;
  logic [5:0]         ld_cnt;
  logic signed [63:0] ld_num;
  logic [15:0]        ld_den_now;
  logic [63:0]        ld_mag;
  logic [16:0]        ld_r2;
  logic               ld_ge;
  logic [47:0]        clamp_val;
  logic               clamp_sat;
  logic [47:0]        res_u;
  logic [47:0]        res_v;
  logic [pkus_pkg::STATUS_W-1:0] res_status;

  assign in_ready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;

  always_comb begin
    if (dimension < 5'd2) begin
      dim_eff = 5'd2;
    end else if (dimension > DIM_W'(pkus_pkg::MAX_DIM)) begin
      dim_eff = DIM_W'(pkus_pkg::MAX_DIM);
    end else begin
      dim_eff = dimension;
    end
  end
  assign dim_half = dim_eff[DIM_W-1:1];

  // loading bookkeeping for the current item
  assign full    = (cnt == (PT_W+1)'(pkus_pkg::MAX_POINTS));
  assign ci_inc  = {1'b0, ci} + (CI_W+1)'(1);
  assign pt_done = (DIM_W'(ci_inc) >= dim_eff);
  always_comb begin
    cnt_new = cnt;
    ci_new  = ci;
    ovf_new = ovf;
    if (full) begin
      ovf_new = 1'b1;
    end else if (pt_done) begin
      ci_new  = '0;
      cnt_new = cnt + (PT_W+1)'(1);
    end else begin
      ci_new = ci_inc[CI_W-1:0];
    end
  end

  // store write on loading, one read a cycle for the burst
  assign rd_addr = (state == S_DOT_RA) ? {pi, cc} : {pj, cc};
  always_ff @(posedge clk) begin
    if (in_valid && in_ready && !full) begin
      store[{cnt[PT_W-1:0], ci}] <= in_data.coord;
    end
    rd_data <= store[rd_addr];
  end

  always_ff @(posedge clk) begin
    mul_p <= mul_a * mul_b;
  end

  // combinational helpers for the sequencer
  assign base = (56'sd1 <<< 44) + $signed({12'd0, rsq, 12'd0})
              - $signed({mul_p[54:0], 1'b0});
  assign prod   = mul_p[63:0];
  assign se_val = fe[0] ? ((fe - 12'sd31) >>> 1) : ((fe - 12'sd32) >>> 1);
  assign s_rem2  = {srem, sx[63:62]};
  assign s_trial = {1'b0, sres, 2'b01};
  assign s_ge    = (s_rem2 >= s_trial);
  assign s_amt   = -13'sd8 - $signed({pe[11], pe});
  assign d_r2    = {rr[31:0], 1'b0};
  assign d_ge    = (d_r2 >= {1'b0, pm});
  assign d_qn    = {qq[47:0], d_ge};
  assign add_res = sat_add((pj < pi) ? lower_sum : diag_sum, 64'(term));
  assign fin_res = (state == S_FIN1) ? sat_add(lower_sum, lower_sum)
                                     : sat_add(two_lower, diag_sum);
  assign ld_num     = ld_sel ? total : two_lower;
  assign ld_den_now = ld_sel ? 16'(n_pts) : mul_p[15:0];
  assign ld_mag     = (ld_num[63] ? (64'd0 - 64'(ld_num)) : 64'(ld_num))
                    + 64'(ld_den_now >> 1);
  assign ld_r2      = {ld_rem[15:0], ld_q[63]};
  assign ld_ge      = (ld_r2 >= {1'b0, ld_den});

  always_comb begin
    clamp_sat = 1'b0;
    if (!ld_neg) begin
      if (ld_q > 64'(POS48)) begin
        clamp_val = POS48;
        clamp_sat = 1'b1;
      end else begin
        clamp_val = ld_q[47:0];
      end
    end else begin
      if (ld_q > 64'(NEG48)) begin
        clamp_val = NEG48;
        clamp_sat = 1'b1;
      end else begin
        clamp_val = 48'd0 - ld_q[47:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      ci        <= '0;
      ovf       <= 1'b0;
      out_valid <= 1'b0;
      rho       <= pkus_pkg::RHO_RESET;
      dimension <= pkus_pkg::DIM_RESET;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          pkus_pkg::REG_RHO: rho <= cfg_data;
          pkus_pkg::REG_DIM: dimension <= cfg_data[DIM_W-1:0];
          default: ;
        endcase
      end
      // S_EMIT reloads the output register itself
      if (out_valid && out_ready && state != S_EMIT) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (in_valid) begin
            if (in_data.last) begin
              // end of sample: clear loading state, check the shape
              cnt   <= '0;
              ci    <= '0;
              ovf   <= 1'b0;
              n_pts <= cnt_new;
              res_u <= '0;
              res_v <= '0;
              if (ovf_new) begin
                res_status <= pkus_pkg::ST_TOO_MANY;
                state      <= S_EMIT;
              end else if (ci_new != '0) begin
                res_status <= pkus_pkg::ST_INCOMPLETE;
                state      <= S_EMIT;
              end else if (cnt_new < (PT_W+1)'(2)) begin
                res_status <= pkus_pkg::ST_FEW;
                state      <= S_EMIT;
              end else begin
                state <= S_RSQ;
              end
            end else begin
              cnt <= cnt_new;
              ci  <= ci_new;
              ovf <= ovf_new;
            end
          end
        end
        S_RSQ: begin
          mul_a     <= {17'd0, rho};
          mul_b     <= {21'd0, rho};
          pi        <= '0;
          pj        <= '0;
          lower_sum <= '0;
          diag_sum  <= '0;
          sat       <= 1'b0;
          state     <= S_RSQ_W;
        end
        S_RSQ_W: state <= S_RSQ_GET;
        S_RSQ_GET: begin
          rsq   <= mul_p[31:0];
          cc    <= '0;
          dot   <= '0;
          state <= S_DOT_RA;
        end
        S_DOT_RA: state <= S_DOT_RB;
        S_DOT_RB: begin
          mul_a <= {{17{rd_data[15]}}, rd_data};
          state <= S_DOT_MB;
        end
        S_DOT_MB: begin
          mul_b <= {{21{rd_data[15]}}, rd_data};
          state <= S_DOT_W;
        end
        S_DOT_W: state <= S_DOT_ACC;
        S_DOT_ACC: begin
          // low bits of the signed product keep its sign at this width
          dot <= dot + mul_p[36:0];
          if ({1'b0, cc} == DIM_W'(dim_eff - 5'd1)) begin
            state <= S_BASE_M;
          end else begin
            cc    <= cc + CI_W'(1);
            state <= S_DOT_RA;
          end
        end
        S_BASE_M: begin
          mul_a <= {17'd0, rho};
          mul_b <= dot;
          state <= S_BASE_W;
        end
        S_BASE_W: state <= S_BASE;
        S_BASE: begin
          if (base[55] || base == '0) begin
            term  <= TERM_MAX;
            sat   <= 1'b1;
            state <= S_ACC;
          end else begin
            nx    <= {8'd0, base};
            sh    <= '0;
            state <= S_NORM;
          end
        end
        S_NORM: begin
          // shift until the leading one reaches the top bit
          if (nx[63]) begin
            fm       <= nx[63:32];
            fe       <= -12'sd12 - $signed({6'd0, sh});
            pm       <= nx[63:32];
            pe       <= -12'sd12 - $signed({6'd0, sh});
            kk       <= (DIM_W-1)'(1);
            last_mul <= 1'b0;
            if (dim_half > (DIM_W-1)'(1)) begin
              state <= S_POW_M;
            end else if (dim_eff[0]) begin
              state <= S_SQRT_INIT;
            end else begin
              state <= S_DIV_INIT;
            end
          end else if (nx[63:56] == 8'd0) begin
            nx <= {nx[55:0], 8'd0};
            sh <= sh + 6'd8;
          end else begin
            nx <= {nx[62:0], 1'b0};
            sh <= sh + 6'd1;
          end
        end
        S_POW_M: begin
          mul_a <= {1'b0, pm};
          mul_b <= {5'd0, fm};
          state <= S_POW_W;
        end
        S_POW_W: state <= S_POW_N;
        S_POW_N: begin
          if (prod[63]) begin
            pm <= prod[63:32];
            pe <= pe + fe + 12'sd32;
          end else begin
            pm <= prod[62:31];
            pe <= pe + fe + 12'sd31;
          end
          if (last_mul) begin
            state <= S_DIV_INIT;
          end else if ((kk + (DIM_W-1)'(1)) < dim_half) begin
            kk    <= kk + (DIM_W-1)'(1);
            state <= S_POW_M;
          end else if (dim_eff[0]) begin
            state <= S_SQRT_INIT;
          end else begin
            state <= S_DIV_INIT;
          end
        end
        S_SQRT_INIT: begin
          // radicand with even exponent
          sx    <= fe[0] ? {1'b0, fm, 31'd0} : {fm, 32'd0};
          sres  <= '0;
          srem  <= '0;
          scnt  <= '0;
          state <= S_SQRT;
        end
        S_SQRT: begin
          sx   <= {sx[61:0], 2'b00};
          srem <= s_ge ? 33'(s_rem2 - s_trial) : s_rem2[32:0];
          sres <= {sres[30:0], s_ge};
          scnt <= scnt + 5'd1;
          if (scnt == 5'd31) begin
            fm       <= {sres[30:0], s_ge};
            fe       <= se_val;
            last_mul <= 1'b1;
            state    <= S_POW_M;
          end
        end
        S_DIV_INIT: begin
          rr    <= 33'h1_0000_0000 - {1'b0, rsq};
          qq    <= '0;
          state <= S_DIV_QR;
        end
        S_DIV_QR: begin
          // integer part is at most two
          if (rr >= {1'b0, pm}) begin
            rr <= rr - {1'b0, pm};
            qq <= qq + 49'd1;
          end else if (s_amt < 0) begin
            qq    <= (s_amt == -13'sd1) ? (qq >> 1) : '0;
            state <= S_TERM;
          end else begin
            dcnt  <= s_amt[11:0];
            state <= S_DIV_SH;
          end
        end
        S_DIV_SH: begin
          if (dcnt == '0) begin
            state <= S_TERM;
          end else if (d_qn[48]) begin
            qq    <= Q_SAT;
            sat   <= 1'b1;
            state <= S_TERM;
          end else begin
            qq   <= d_qn;
            rr   <= d_ge ? (d_r2 - {1'b0, pm}) : d_r2;
            dcnt <= dcnt - 12'd1;
          end
        end
        S_TERM: begin
          if (qq >= TERM_LIM) begin
            term <= TERM_MAX;
            sat  <= 1'b1;
          end else begin
            term <= $signed(qq - ONE_Q24);
          end
          state <= S_ACC;
        end
        S_ACC: begin
          if (pj < pi) begin
            lower_sum <= add_res[63:0];
          end else begin
            diag_sum <= add_res[63:0];
          end
          if (add_res[64]) begin
            sat <= 1'b1;
          end
          cc  <= '0;
          dot <= '0;
          if (pj == pi) begin
            if ({1'b0, pi} == n_pts - (PT_W+1)'(1)) begin
              state <= S_FIN1;
            end else begin
              pi    <= pi + PT_W'(1);
              pj    <= '0;
              state <= S_DOT_RA;
            end
          end else begin
            pj    <= pj + PT_W'(1);
            state <= S_DOT_RA;
          end
        end
        S_FIN1: begin
          two_lower <= fin_res[63:0];
          if (fin_res[64]) sat <= 1'b1;
          mul_a <= {24'd0, n_pts};
          mul_b <= {28'd0, n_pts - (PT_W+1)'(1)};
          ld_sel <= 1'b0;
          state  <= S_FIN2;
        end
        S_FIN2: begin
          total <= fin_res[63:0];
          if (fin_res[64]) sat <= 1'b1;
          state <= S_LD_INIT;
        end
        S_LD_INIT: begin
          ld_neg <= ld_num[63];
          ld_q   <= ld_mag;
          ld_den <= ld_den_now;
          ld_rem <= '0;
          ld_cnt <= '0;
          state  <= S_LD;
        end
        S_LD: begin
          ld_rem <= ld_ge ? (ld_r2 - {1'b0, ld_den}) : ld_r2;
          ld_q   <= {ld_q[62:0], ld_ge};
          ld_cnt <= ld_cnt + 6'd1;
          if (ld_cnt == 6'd63) begin
            state <= S_LD_DONE;
          end
        end
        S_LD_DONE: begin
          if (clamp_sat) sat <= 1'b1;
          if (!ld_sel) begin
            res_u  <= clamp_val;
            ld_sel <= 1'b1;
            state  <= S_LD_INIT;
          end else begin
            res_v      <= clamp_val;
            res_status <= (sat || clamp_sat) ? pkus_pkg::ST_SATURATED : pkus_pkg::ST_OK;
            state      <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (!out_valid || out_ready) begin
            out_data.u_stat <= res_u;
            out_data.v_stat <= res_v;
            out_data.status <= res_status;
            out_valid       <= 1'b1;
            state           <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // a closing item always leaves the loading state
  a_last_blocks: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && in_data.last) |=> !in_ready)
    else $error("input still taken after last item");

  // the point count never passes the store size
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= (PT_W+1)'(pkus_pkg::MAX_POINTS))
    else $error("point count overflow");

  // error results carry zero statistics
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (out_data.status == pkus_pkg::ST_FEW
                || out_data.status == pkus_pkg::ST_INCOMPLETE
                || out_data.status == pkus_pkg::ST_TOO_MANY))
    |-> (out_data.u_stat == '0 && out_data.v_stat == '0))
    else $error("error result with nonzero statistic");

  // mantissas entering the multiplier are normalized
  a_norm: assert property (@(posedge clk) disable iff (rst)
    (state == S_POW_M) |-> (pm[31] && fm[31]))
    else $error("unnormalized mantissa");

  // coordinate index stays inside the point
  a_coord: assert property (@(posedge clk) disable iff (rst)
    (state == S_DOT_ACC) |-> ({1'b0, cc} < dim_eff))
    else $error("coordinate index past dimension");

endmodule

// File: test/tb_poisson_kernel_uniformity_statistic.sv
// Testbench for the Poisson-kernel uniformity statistic block.
// Drives samples of points, predicts U, V and status per sample, checks each result.
// Depends on pkus_pkg and poisson_kernel_uniformity_statistic.
`timescale 1ns / 100ps

module tb_poisson_kernel_uniformity_statistic;

  localparam longint POS48 = 64'sd140737488355327;
  localparam longint NEG48 = -64'sd140737488355328;
  localparam longint ONE_Q24 = 64'sd16777216;
  localparam int IDLE_LIMIT = 400000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  pkus_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  pkus_pkg::out_item_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [pkus_pkg::CFG_IDX_W-1:0] cfg_index = pkus_pkg::REG_RHO;
  logic [pkus_pkg::RHO_W-1:0] cfg_data = '0;

  poisson_kernel_uniformity_statistic dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // predictor state: shadow of the point store, counters, sums, registers
  logic [pkus_pkg::COORD_W-1:0] shadow_pts [pkus_pkg::STORE_SIZE];
  int unsigned pts_loaded, coord_pos;
  bit store_overflow;
  longint lower_acc, diag_acc;
  logic [pkus_pkg::RHO_W-1:0] rho_reg = pkus_pkg::RHO_RESET;
  logic [pkus_pkg::DIM_W-1:0] dim_reg = pkus_pkg::DIM_RESET;
  bit sat_seen;

  pkus_pkg::in_item_t pending_coords [$];
  pkus_pkg::out_item_t expected_stats [$];
  int errors = 0;
  int idle_cycles = 0;
  bit in_fire = 1'b0;
  int in_gap = 0, out_gap = 0, hold_left = 0;
  bit quiet = 1'b0;      // no random gaps on either side while set
  bit long_hold = 1'b0;  // asks the receiver for one long stall

  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic longint sat_sum(longint a, longint b);
    longint s;
    s = a + b;
    if (b > 0 && s < a) begin sat_seen = 1'b1; return 64'sh7FFFFFFFFFFFFFFF; end
    if (b < 0 && s > a) begin sat_seen = 1'b1; return 64'sh8000000000000000; end
    return s;
  endfunction

  // mantissa product renormalized to 32 bits
  function automatic void mant_mul(inout bit [63:0] m, inout int e, input bit [63:0] m2,
                                   input int e2);
    bit [63:0] p;
    p = m * m2;
    if (p[63]) begin m = p >> 32; e = e + e2 + 32; end
    else begin m = p >> 31; e = e + e2 + 31; end
  endfunction

  function automatic bit [63:0] floor_sqrt(bit [63:0] x);
    bit [63:0] res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= res + b) begin x = x - (res + b); res = (res >> 1) + b; end
      else res = res >> 1;
      b = b >> 2;
    end
    return res;
  endfunction

  // floor(num * 2^s / m), capped at 2^48
  function automatic bit [63:0] shift_div(bit [63:0] num, bit [63:0] m, int s);
    bit [63:0] q, r;
    q = num / m;
    r = num % m;
    if (s < 0) begin
      if (s <= -63) return 0;
      return q >> (-s);
    end
    for (int i = 0; i < s; i++) begin
      q = q << 1;
      r = r << 1;
      if (r >= m) begin r = r - m; q[0] = 1'b1; end
      if (q >= (64'd1 << 48)) begin sat_seen = 1'b1; return 64'd1 << 48; end
    end
    return q;
  endfunction

  // Poisson kernel term for the pair (a, b), Q24.24
  function automatic longint kernel_term(int a, int b, int dim);
    longint d, base, rl;
    bit [63:0] x, m, pm, sm, num;
    int e, pe, se, top;
    d = 0;
    for (int c = 0; c < dim; c++)
      d += longint'($signed(shadow_pts[a*pkus_pkg::MAX_DIM+c]))
         * longint'($signed(shadow_pts[b*pkus_pkg::MAX_DIM+c]));
    rl = longint'(rho_reg);
    base = (64'sd1 <<< 44) + ((rl * rl) <<< 12) - 2 * rl * d;
    if (base <= 0) begin sat_seen = 1'b1; return POS48; end
    x = base;
    top = 0;
    while (top < 63 && (x >> (top + 1)) != 0) top++;
    m = (top >= 31) ? (x >> (top - 31)) : (x << (31 - top));
    e = top - 31 - 44;
    pm = m;
    pe = e;
    for (int k = 1; k < dim / 2; k++) mant_mul(pm, pe, m, e);
    if (dim % 2 != 0) begin
      // square root with an even exponent
      if (e % 2 != 0) begin sm = floor_sqrt(m << 31); se = (e - 31) / 2; end
      else begin sm = floor_sqrt(m << 32); se = (e - 32) / 2; end
      mant_mul(pm, pe, sm, se);
    end
    num = (64'd1 << 32) - 64'(rl * rl);
    x = shift_div(num, pm, -8 - pe);
    if (x >= (64'd1 << 47) + 64'(ONE_Q24)) begin sat_seen = 1'b1; return POS48; end
    return longint'(x) - ONE_Q24;
  endfunction

  function automatic longint rounded_quot(longint n, bit [63:0] den);
    bit neg;
    bit [63:0] mag, q;
    longint v;
    neg = n < 0;
    mag = neg ? 64'(-n) : 64'(n);
    q = (mag + den / 2) / den;
    v = neg ? -longint'(q) : longint'(q);
    if (v > POS48) begin sat_seen = 1'b1; return POS48; end
    if (v < NEG48) begin sat_seen = 1'b1; return NEG48; end
    return v;
  endfunction

  // one accepted coordinate item; a last item yields one expected result
  task automatic predict_statistic(pkus_pkg::in_item_t it);
    int dim, n;
    longint two_lower, total, u, v;
    pkus_pkg::out_item_t res;
    dim = (dim_reg < 2) ? 2 : ((dim_reg > pkus_pkg::MAX_DIM) ? pkus_pkg::MAX_DIM
                                                              : int'(dim_reg));
    if (pts_loaded >= pkus_pkg::MAX_POINTS) store_overflow = 1'b1;
    else begin
      shadow_pts[pts_loaded*pkus_pkg::MAX_DIM+coord_pos] = it.coord;
      coord_pos++;
      if (coord_pos >= dim) begin coord_pos = 0; pts_loaded++; end
    end
    if (!it.last) return;
    n = pts_loaded;
    u = 0;
    v = 0;
    sat_seen = 1'b0;
    if (store_overflow) res.status = pkus_pkg::ST_TOO_MANY;
    else if (coord_pos != 0) res.status = pkus_pkg::ST_INCOMPLETE;
    else if (n < 2) res.status = pkus_pkg::ST_FEW;
    else begin
      for (int i = 0; i < n; i++)
        for (int j = 0; j <= i; j++) begin
          if (j < i) lower_acc = sat_sum(lower_acc, kernel_term(i, j, dim));
          else diag_acc = sat_sum(diag_acc, kernel_term(i, j, dim));
        end
      two_lower = sat_sum(lower_acc, lower_acc);
      total = sat_sum(two_lower, diag_acc);
      u = rounded_quot(two_lower, 64'(n) * 64'(n - 1));
      v = rounded_quot(total, 64'(n));
      res.status = sat_seen ? pkus_pkg::ST_SATURATED : pkus_pkg::ST_OK;
    end
    res.u_stat = u[pkus_pkg::STAT_W-1:0];
    res.v_stat = v[pkus_pkg::STAT_W-1:0];
    expected_stats.push_back(res);
    pts_loaded = 0;
    coord_pos = 0;
    store_overflow = 1'b0;
    lower_acc = 0;
    diag_acc = 0;
  endtask

  // sender: raises valid at the falling edge, holds it until the item is taken
  always @(negedge clk) begin
    if (!rst && (!in_valid || in_fire)) begin
      if (in_gap > 0) begin
        in_gap <= in_gap - 1;
        in_valid <= 1'b0;
      end else if (pending_coords.size() > 0) begin
        in_valid <= 1'b1;
        in_data <= pending_coords.pop_front();
        in_gap <= pick_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver: random stalls, plus one long hold on request
  always @(negedge clk) begin
    if (!rst) begin
      if (long_hold) begin
        long_hold <= 1'b0;
        hold_left <= 2500;
        out_ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_ready <= 1'b0;
      end else if (out_gap > 0) begin
        out_gap <= out_gap - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        out_gap <= pick_gap();
      end
    end
  end

  // sampling at the rising edge: prediction, result check, register shadow, watchdog
  always @(posedge clk) begin
    pkus_pkg::out_item_t exp_res;
    if (!rst) begin
      in_fire <= in_valid && in_ready;
      if (in_valid && in_ready) predict_statistic(in_data);
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == pkus_pkg::REG_RHO) rho_reg = cfg_data;
        else if (cfg_index == pkus_pkg::REG_DIM) dim_reg = cfg_data[pkus_pkg::DIM_W-1:0];
      end
      if (out_valid && out_ready) begin
        if (expected_stats.size() == 0) begin
          $error("result with none expected: u_stat %0d v_stat %0d status %0d",
                 out_data.u_stat, out_data.v_stat, out_data.status);
          errors++;
        end else begin
          exp_res = expected_stats.pop_front();
          if (out_data.u_stat !== exp_res.u_stat) begin
            $error("u_stat expected %0d actual %0d", exp_res.u_stat, out_data.u_stat);
            errors++;
          end
          if (out_data.v_stat !== exp_res.v_stat) begin
            $error("v_stat expected %0d actual %0d", exp_res.v_stat, out_data.v_stat);
            errors++;
          end
          if (out_data.status !== exp_res.status) begin
            $error("status expected %0d actual %0d", exp_res.status, out_data.status);
            errors++;
          end
        end
      end
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  function automatic logic signed [pkus_pkg::COORD_W-1:0] rand_coord();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 16'sd16384;
    if (r == 1) return -16'sd16384;
    if (r == 2) return 16'sd0;
    return pkus_pkg::COORD_W'($urandom_range(0, 32768) - 16384);
  endfunction

  // queue a sample of npts points; cut > 0 ends it early with last at that item
  task automatic queue_sample(int npts, int dim, int cut);
    pkus_pkg::in_item_t it;
    int total;
    total = (cut > 0) ? cut : npts * dim;
    for (int k = 0; k < total; k++) begin
      it.coord = rand_coord();
      it.last = (k == total - 1);
      pending_coords.push_back(it);
    end
  endtask

  // one point with every coordinate set to v
  task automatic queue_flat_point(logic signed [pkus_pkg::COORD_W-1:0] v, int dim, bit fin);
    pkus_pkg::in_item_t it;
    for (int k = 0; k < dim; k++) begin
      it.coord = v;
      it.last = fin && (k == dim - 1);
      pending_coords.push_back(it);
    end
  endtask

  task automatic wait_drained();
    while (pending_coords.size() != 0 || in_valid || expected_stats.size() != 0)
      @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(logic [pkus_pkg::CFG_IDX_W-1:0] idx,
                           logic [pkus_pkg::RHO_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int dims [8] = '{3, 2, 16, 0, 31, 7, 1, 5};
    int rhos [8];
    int eff, sent, npts, r, cut;
    rhos = '{32768, 0, 65535, 40000, 12345, 60000, 1, 52000};
    for (int i = 3; i < 8; i++) if (i != 6) rhos[i] = $urandom_range(0, 65535);
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: saturating identical points, opposite points, one point, short sample, two random points
    queue_flat_point(16'sd16384, 3, 0);
    queue_flat_point(16'sd16384, 3, 1);
    queue_flat_point(16'sd16384, 3, 0);
    queue_flat_point(-16'sd16384, 3, 1);
    queue_flat_point(-16'sd9459, 3, 1);
    queue_sample(1, 3, 2);
    queue_sample(2, 3, 0);
    wait_drained();

    sent = 0;
    for (int ph = 0; ph < 8; ph++) begin
      if (ph > 0) begin
        wait_drained();
        write_reg(pkus_pkg::REG_RHO, pkus_pkg::RHO_W'(rhos[ph]));
        write_reg(pkus_pkg::REG_DIM, {11'($urandom_range(0, 2047)), 5'(dims[ph])});
      end
      eff = (dims[ph] < 2) ? 2
          : ((dims[ph] > pkus_pkg::MAX_DIM) ? pkus_pkg::MAX_DIM : dims[ph]);
      if (ph == 1) begin
        // store overflow: more points than the store holds
        queue_sample(pkus_pkg::MAX_POINTS + 2, eff, 0);
        sent += (pkus_pkg::MAX_POINTS + 2) * eff;
      end
      if (ph == 3) begin
        // receiver holds off while several samples stack up behind it
        long_hold = 1'b1;
        for (int s = 0; s < 4; s++) queue_sample($urandom_range(2, 3), eff, 0);
      end
      while (sent < (ph + 1) * 100) begin
        quiet = ($urandom_range(0, 5) == 0);
        r = $urandom_range(0, 19);
        npts = (eff > 8) ? $urandom_range(2, 4) : $urandom_range(2, 6);
        if (r < 15) begin
          queue_sample(npts, eff, 0);
          sent += npts * eff;
        end else if (r < 17) begin
          cut = $urandom_range(1, npts * eff - 1);
          queue_sample(npts, eff, cut);
          sent += cut;
        end else begin
          queue_sample(1, eff, 0);
          sent += eff;
        end
        if (r == 5) wait_drained();
        while (pending_coords.size() > 64) @(posedge clk);
      end
    end

    wait_drained();
    repeat (200) @(posedge clk);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// File: sim.f
design/pkus_pkg.sv
design/poisson_kernel_uniformity_statistic.sv
test/tb_poisson_kernel_uniformity_statistic.sv
